[sv/voxel_shape_fill_engine_top_defines.svh]
// Assertion macros for the voxel shape fill engine.
// Included by the top level only; no other dependencies.
`ifndef VOXEL_SHAPE_FILL_ENGINE_TOP_DEFINES_SVH
`define VOXEL_SHAPE_FILL_ENGINE_TOP_DEFINES_SVH
// Implication checked on every clock, quiet during reset
`define VSF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// Next-cycle implication, quiet during reset
`define VSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`endif

[sv/vsf_pkg.sv]
// Package for the voxel shape fill engine: operation codes, register
// indexes, controller states and the controller/datapath command struct.
`timescale 1ns / 1ps
package vsf_pkg;
   typedef enum logic [3:0] {
      OP_SET_VOXEL = 4'd0, OP_CLR_VOXEL = 4'd1, OP_SET_BOX = 4'd2,
      OP_CLR_BOX = 4'd3, OP_SET_SPHERE = 4'd4, OP_CLR_SPHERE = 4'd5,
      OP_SET_ELLIP = 4'd6, OP_CLR_ELLIP = 4'd7, OP_READ_VOXEL = 4'd8
   } op_type;

   localparam logic [1:0] REG_RED = 2'd0, REG_GREEN = 2'd1, REG_BLUE = 2'd2,
                          REG_ALPHA = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_CHECK, ST_SCAN, ST_READ, ST_RESP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_run;  // sweep writing zero words
      logic load;       // capture request, reset scan counter
      logic scan_run;   // advance scan counter, write hits
      logic read_go;    // issue single read
      logic single_wr;  // single voxel write
      logic rsp_load;   // capture response
      logic rsp_take;   // response consumed
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;  // pipeline drained
      logic error;      // captured request is out of range
      logic noop;       // nothing to write, no error
      logic is_read;
      logic is_single;
      logic rsp_valid;
   } status_type;
endpackage

[sv/voxel_shape_fill_engine_top.sv]
// Voxel shape fill engine top level: config registers, controller, datapath.
// Request accept to response valid: single writes, errors and no-ops pass
// through CHECK; reads through CHECK and READ; scans through CHECK and SCAN.
// Throughput: one transaction in flight; the next request is taken the cycle
// after the response.
// Reset: synchronous; a clearing pass over every voxel zeroes the store,
// during which no request is taken.
`timescale 1ns / 1ps
module voxel_shape_fill_engine_top #(
   parameter int GRID_X = 32,
   parameter int GRID_Y = 32,
   parameter int GRID_Z = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[3:0], px[9:4], py[15:10], pz[21:16], qx[27:22], qy[33:28],
   // qz[39:34], radius[45:40], zero fill [47:46]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // range_error[0], voxel_on[1], voxel_red[9:2], voxel_green[17:10],
   // voxel_blue[25:18], voxel_alpha[33:26], zero fill [39:34]
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import vsf_pkg::*;
   `include "voxel_shape_fill_engine_top_defines.svh"

   // Paint registers
   logic [7:0] red_ff, green_ff, blue_ff, alpha_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff <= '0; green_ff <= '0; blue_ff <= '0; alpha_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_RED:   red_ff   <= csr_data;
            REG_GREEN: green_ff <= csr_data;
            REG_BLUE:  blue_ff  <= csr_data;
            REG_ALPHA: alpha_ff <= csr_data;
            default: ;
         endcase
      end
   end

   cmd_type    cmd;
   status_type sts;
   logic        rsp_error;
   logic [32:0] rsp_word;

   vsf_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tready, .sts, .cmd
   );

   vsf_datapath #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_dp (
      .clock, .reset, .cmd, .sts,
      .op(req_tdata[3:0]), .px(req_tdata[9:4]), .py(req_tdata[15:10]),
      .pz(req_tdata[21:16]), .qx(req_tdata[27:22]), .qy(req_tdata[33:28]),
      .qz(req_tdata[39:34]), .rad(req_tdata[45:40]),
      .paint({red_ff, green_ff, blue_ff, alpha_ff}),
      .rsp_error, .rsp_word
   );

   assign rsp_tvalid = sts.rsp_valid;
   assign rsp_tdata  = {6'd0, rsp_word[7:0], rsp_word[15:8], rsp_word[23:16],
                        rsp_word[31:24], rsp_word[32], rsp_error};

   `VSF_ASSERT_IMP(a_no_accept_busy, clock, reset, req_tready, !rsp_tvalid)
   `VSF_ASSERT_IMP(a_err_no_read, clock, reset, rsp_tvalid && rsp_tdata[0],
                   rsp_tdata[1] == 1'b0)
   `VSF_ASSERT_NEXT(a_rsp_clears, clock, reset, rsp_tvalid && rsp_tready,
                    !rsp_tvalid)
endmodule

[sv/vsf_ctrl.sv]
// Controller state machine for the voxel shape fill engine.
// Depends on vsf_pkg.
`timescale 1ns / 1ps
module vsf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                rsp_tready,
   input  vsf_pkg::status_type sts,
   output vsf_pkg::cmd_type    cmd
);
   import vsf_pkg::*;

   state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (sts.scan_done) state_in = ST_IDLE;
         ST_IDLE:  if (req_tvalid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (sts.error || sts.noop)  state_in = ST_RESP;
            else if (sts.is_read)       state_in = ST_READ;
            else if (sts.is_single)     state_in = ST_RESP;
            else                        state_in = ST_SCAN;
         end
         ST_SCAN:  if (sts.scan_done) state_in = ST_RESP;
         ST_READ:  state_in = ST_RESP;
         ST_RESP:  if (sts.rsp_valid && rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_run = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_CHECK: begin
            cmd.read_go   = sts.is_read && !sts.error;
            cmd.single_wr = sts.is_single && !sts.error && !sts.is_read;
            cmd.rsp_load  = sts.error || sts.noop || (sts.is_single && !sts.is_read);
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            cmd.rsp_load = sts.scan_done;
         end
         ST_READ: cmd.rsp_load = 1'b1;
         ST_RESP: cmd.rsp_take = sts.rsp_valid && rsp_tready;
         default: ;
      endcase
   end
endmodule

[sv/vsf_datapath.sv]
// Datapath for the voxel shape fill engine: voxel memory, scan counter,
// shape membership pipeline and response register. Depends on vsf_pkg.
`timescale 1ns / 1ps
module vsf_datapath #(
   parameter int GRID_X = 32,
   parameter int GRID_Y = 32,
   parameter int GRID_Z = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  vsf_pkg::cmd_type   cmd,
   output vsf_pkg::status_type sts,
   input  logic [3:0]         op,
   input  logic [5:0]         px, py, pz, qx, qy, qz, rad,
   input  logic [31:0]        paint,
   output logic               rsp_error,
   output logic [32:0]        rsp_word
);
   import vsf_pkg::*;

   localparam int XW = (GRID_X > 1) ? $clog2(GRID_X) : 1;
   localparam int YW = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
   localparam int ZW = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
   localparam int AW = XW + YW + ZW;
   localparam int DEPTH = 1 << AW;

   // Captured request
   logic [3:0] op_ff;
   logic [5:0] px_ff, py_ff, pz_ff, qx_ff, qy_ff, qz_ff, r_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= op; px_ff <= px; py_ff <= py; pz_ff <= pz;
         qx_ff <= qx; qy_ff <= qy; qz_ff <= qz; r_ff <= rad;
      end
   end

   // Range decode
   logic is_single, is_read, is_box_s, is_sph, is_ell, err, noop;
   logic [6:0] ex, ey, ez;
   always_comb begin
      is_single = (op_ff == OP_SET_VOXEL) || (op_ff == OP_CLR_VOXEL) ||
                  (op_ff == OP_READ_VOXEL);
      is_read   = (op_ff == OP_READ_VOXEL);
      is_box_s  = (op_ff == OP_SET_BOX);
      is_sph    = (op_ff == OP_SET_SPHERE) || (op_ff == OP_CLR_SPHERE);
      is_ell    = (op_ff == OP_SET_ELLIP) || (op_ff == OP_CLR_ELLIP);
      ex = is_ell ? 7'(px_ff) + 7'(qx_ff) : 7'(px_ff) + 7'(r_ff);
      ey = is_ell ? 7'(py_ff) + 7'(qy_ff) : 7'(py_ff) + 7'(r_ff);
      ez = is_ell ? 7'(pz_ff) + 7'(qz_ff) : 7'(pz_ff) + 7'(r_ff);
      err  = 1'b0;
      noop = 1'b0;
      case (op_ff)
         OP_SET_VOXEL, OP_CLR_VOXEL, OP_READ_VOXEL:
            err = (7'(px_ff) >= 7'(GRID_X)) || (7'(py_ff) >= 7'(GRID_Y)) ||
                  (7'(pz_ff) >= 7'(GRID_Z));
         OP_SET_BOX: begin
            noop = (qx_ff <= px_ff) || (qy_ff <= py_ff) || (qz_ff <= pz_ff);
            err  = !noop && ((7'(qx_ff) > 7'(GRID_X)) || (7'(qy_ff) > 7'(GRID_Y)) ||
                             (7'(qz_ff) > 7'(GRID_Z)));
         end
         OP_CLR_BOX: begin
            noop = (qx_ff < px_ff) || (qy_ff < py_ff) || (qz_ff < pz_ff);
            err  = !noop && ((7'(qx_ff) >= 7'(GRID_X)) || (7'(qy_ff) >= 7'(GRID_Y)) ||
                             (7'(qz_ff) >= 7'(GRID_Z)));
         end
         OP_SET_SPHERE, OP_CLR_SPHERE, OP_SET_ELLIP, OP_CLR_ELLIP: begin
            err  = (ex >= 7'(GRID_X)) || (ey >= 7'(GRID_Y)) || (ez >= 7'(GRID_Z));
            noop = !err && is_ell && ((qx_ff == '0) || (qy_ff == '0) || (qz_ff == '0));
         end
         default: noop = 1'b1;
      endcase
   end

   // Scan counter, z fastest, then y, then x
   logic [XW-1:0] sx_ff, sx_in;
   logic [YW-1:0] sy_ff, sy_in;
   logic [ZW-1:0] sz_ff, sz_in;
   logic          sactive_ff, sactive_in, slast;
   always_comb begin
      slast = (32'(sx_ff) == GRID_X - 1) && (32'(sy_ff) == GRID_Y - 1) &&
              (32'(sz_ff) == GRID_Z - 1);
      sx_in = sx_ff; sy_in = sy_ff; sz_in = sz_ff; sactive_in = sactive_ff;
      if (cmd.load) begin
         sx_in = '0; sy_in = '0; sz_in = '0; sactive_in = 1'b1;
      end else if ((cmd.scan_run || cmd.clear_run) && sactive_ff) begin
         if (slast) sactive_in = 1'b0;
         if (32'(sz_ff) == GRID_Z - 1) begin
            sz_in = '0;
            if (32'(sy_ff) == GRID_Y - 1) begin
               sy_in = '0;
               sx_in = sx_ff + 1'b1;
            end else sy_in = sy_ff + 1'b1;
         end else sz_in = sz_ff + 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff <= '0; sy_ff <= '0; sz_ff <= '0; sactive_ff <= 1'b1;
      end else begin
         sx_ff <= sx_in; sy_ff <= sy_in; sz_ff <= sz_in; sactive_ff <= sactive_in;
      end
   end

   // Stage 1: distances and squares
   logic        v1_ff, c1_ff;
   logic [AW-1:0] a1_ff, a2_ff, a3_ff, a4_ff;
   logic [11:0] dx2_ff, dy2_ff, dz2_ff;
   logic        box1_ff;
   logic [5:0]  dx, dy, dz;
   logic [6:0]  ux, uy, uz;
   always_comb begin
      ux = 7'(sx_ff); uy = 7'(sy_ff); uz = 7'(sz_ff);
      dx = (ux >= 7'(px_ff)) ? 6'(ux - 7'(px_ff)) : 6'(7'(px_ff) - ux);
      dy = (uy >= 7'(py_ff)) ? 6'(uy - 7'(py_ff)) : 6'(7'(py_ff) - uy);
      dz = (uz >= 7'(pz_ff)) ? 6'(uz - 7'(pz_ff)) : 6'(7'(pz_ff) - uz);
   end
   always_ff @(posedge clock) begin
      dx2_ff <= dx * dx; dy2_ff <= dy * dy; dz2_ff <= dz * dz;
      a1_ff  <= {sx_ff, sy_ff, sz_ff};
      c1_ff  <= cmd.clear_run;
      if (is_box_s)
         box1_ff <= (ux >= 7'(px_ff)) && (ux < 7'(qx_ff)) && (uy >= 7'(py_ff)) &&
                    (uy < 7'(qy_ff)) && (uz >= 7'(pz_ff)) && (uz < 7'(qz_ff));
      else
         box1_ff <= (ux >= 7'(px_ff)) && (ux <= 7'(qx_ff)) && (uy >= 7'(py_ff)) &&
                    (uy <= 7'(qy_ff)) && (uz >= 7'(pz_ff)) && (uz <= 7'(qz_ff));
   end
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= (cmd.scan_run || cmd.clear_run) && sactive_ff;
   end

   // Stage 2: radius squares and products of two
   logic [11:0] ax_ff, ay_ff, az_ff;
   always_ff @(posedge clock) begin
      ax_ff <= is_ell ? qx_ff * qx_ff : r_ff * r_ff;
      ay_ff <= is_ell ? qy_ff * qy_ff : r_ff * r_ff;
      az_ff <= is_ell ? qz_ff * qz_ff : r_ff * r_ff;
   end
   logic        v2_ff, c2_ff, box2_ff;
   logic [11:0] dx2b_ff, dy2b_ff, dz2b_ff;
   logic [23:0] ayaz_ff, axaz_ff, axay_ff;
   always_ff @(posedge clock) begin
      c2_ff <= c1_ff; box2_ff <= box1_ff; a2_ff <= a1_ff;
      dx2b_ff <= dx2_ff; dy2b_ff <= dy2_ff; dz2b_ff <= dz2_ff;
      ayaz_ff <= ay_ff * az_ff; axaz_ff <= ax_ff * az_ff; axay_ff <= ax_ff * ay_ff;
   end
   // Stage 3: products of three
   logic        v3_ff, c3_ff, box3_ff, sph3_ff;
   logic [35:0] tx_ff, ty_ff, tz_ff, tr_ff;
   always_ff @(posedge clock) begin
      c3_ff <= c2_ff; box3_ff <= box2_ff; a3_ff <= a2_ff;
      sph3_ff <= (14'(dx2b_ff) + 14'(dy2b_ff) + 14'(dz2b_ff)) <= 14'(ax_ff);
      tx_ff <= dx2b_ff * ayaz_ff; ty_ff <= dy2b_ff * axaz_ff;
      tz_ff <= dz2b_ff * axay_ff; tr_ff <= ax_ff * ayaz_ff;
   end
   // Stage 4: membership decision
   logic        v4_ff, hit4_ff;
   always_ff @(posedge clock) begin
      a4_ff <= a3_ff;
      if (c3_ff)        hit4_ff <= 1'b1;
      else if (is_sph)  hit4_ff <= sph3_ff;
      else if (is_ell)  hit4_ff <= (38'(tx_ff) + 38'(ty_ff) + 38'(tz_ff)) <= 38'(tr_ff);
      else              hit4_ff <= box3_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
      end
   end

   // Set ops write paint; clear keeps colour, so it writes only the separate
   // on-flag memory and leaves the colour memory untouched.
   logic is_set;
   assign is_set = (op_ff == OP_SET_VOXEL) || (op_ff == OP_SET_BOX) ||
                   (op_ff == OP_SET_SPHERE) || (op_ff == OP_SET_ELLIP);

   // Hold the clearing pass flag until the first request is taken
   logic clr_phase_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_phase_ff <= 1'b1;
      else if (cmd.load) clr_phase_ff <= 1'b0;
   end

   logic [31:0] colour_mem [DEPTH];
   logic        on_mem [DEPTH];
   logic [AW-1:0] single_a;
   logic [AW-1:0] wa;
   logic          we_on, we_col, wd_on;
   always_comb begin
      single_a = {px_ff[XW-1:0], py_ff[YW-1:0], pz_ff[ZW-1:0]};
      we_on  = (v4_ff && hit4_ff) || cmd.single_wr;
      wa     = cmd.single_wr ? single_a : a4_ff;
      wd_on  = c3_ff ? 1'b0 : is_set;
      if (cmd.single_wr) wd_on = is_set;
      else if (!(v4_ff && hit4_ff)) wd_on = 1'b0;
      we_col = we_on && (is_set || clr_phase_ff);
   end

   // Memory write and registered read
   logic        rd_on_ff;
   logic [31:0] rd_col_ff;
   always_ff @(posedge clock) begin
      if (we_on)  on_mem[wa] <= clr_phase_ff ? 1'b0 : wd_on;
      if (we_col) colour_mem[wa] <= clr_phase_ff ? 32'd0 : paint;
      if (cmd.read_go) begin
         rd_on_ff  <= on_mem[single_a];
         rd_col_ff <= colour_mem[single_a];
      end
   end

   // Response register
   logic        rsp_valid_ff, rsp_err_ff;
   logic [32:0] rsp_word_ff;
   logic        read_pend_ff;
   always_ff @(posedge clock) begin
      if (reset) read_pend_ff <= 1'b0;
      else if (cmd.read_go) read_pend_ff <= 1'b1;
      else if (cmd.rsp_load) read_pend_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
      else if (cmd.rsp_take) rsp_valid_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_err_ff  <= err;
         rsp_word_ff <= read_pend_ff ? {rd_on_ff, rd_col_ff} : 33'd0;
      end
   end
   assign rsp_error = rsp_err_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      sts.scan_done = !sactive_ff && !v1_ff && !v2_ff && !v3_ff && !v4_ff;
      sts.error     = err;
      sts.noop      = noop;
      sts.is_read   = is_read;
      sts.is_single = is_single;
      sts.rsp_valid = rsp_valid_ff;
   end
endmodule
